### sv/cct_pkg.sv
// cct_pkg: shared constants, types and helpers for the character class tokenizer
// used by cct_front, cct_fifo, cct_back and char_class_tokenizer; depends on nothing
package cct_pkg;

    // size limits of one query
    localparam int QUERY_BYTES_MAX = 1024;
    localparam int TOKENS_MAX      = 1024;

    // field widths
    localparam int CFG_W   = 11;
    localparam int START_W = 10;
    localparam int LEN_W   = 11;
    localparam int IDX_W   = 10;

    // queue between classifier and tokenizer
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_MAX_QUERY_BYTES = 1'b0,
        REG_MAX_TOKENS      = 1'b1
    } cfg_index_t;

    // class of the run that the previous byte belonged to
    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_LETTER = 2'd1,
        CLS_DIGIT  = 2'd2,
        CLS_HIGH   = 2'd3
    } run_class_t;

    // byte kind found by the classifier
    typedef enum logic [2:0] {
        KIND_LETTER = 3'd0,
        KIND_DIGIT  = 3'd1,
        KIND_HIGH   = 3'd2,
        KIND_SPACE  = 3'd3,
        KIND_PUNCT  = 3'd4,
        KIND_CTRL   = 3'd5
    } byte_kind_t;

    // one classified byte in the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       dia;
        logic       last;
        byte_kind_t kind;
    } item_t;

    // clamped limits in effect
    typedef struct packed {
        logic [CFG_W-1:0] qcap;
        logic [CFG_W-1:0] tcap;
    } caps_t;

    // one result held in the output register
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [IDX_W-1:0]   index;
        logic               last;
    } span_t;

    // zero acts as one, above the limit acts as the limit
    function automatic logic [CFG_W-1:0] clamp_cap(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

### sv/cct_channels.sv
// cct_channels: valid/ready channel interfaces for query bytes and token spans
// depends on nothing
interface cct_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       diacritic_flag;
    logic       query_end;

    modport source (output valid, byte_in, diacritic_flag, query_end, input ready);
    modport sink   (input valid, byte_in, diacritic_flag, query_end, output ready);
endinterface

interface cct_span_if;
    logic        valid;
    logic        ready;
    logic [9:0]  span_start;
    logic [10:0] span_length;
    logic [9:0]  span_index;
    logic        last_of_query;

    modport source (output valid, span_start, span_length, span_index, last_of_query,
                    input ready);
    modport sink   (input valid, span_start, span_length, span_index, last_of_query,
                    output ready);
endinterface

### sv/cct_front.sv
// cct_front: accepts query bytes, classifies each one and pushes it into the queue
// depends on cct_pkg and cct_byte_if
module cct_front (
    cct_byte_if.sink        byte_ch,
    input  logic            fifo_full,
    output logic            push,
    output cct_pkg::item_t  push_item
);

    cct_pkg::byte_kind_t kind;

    // byte class decode
    always_comb
    begin
        logic [7:0] c;
        c = byte_ch.byte_in;
        if (c[7])
            kind = cct_pkg::KIND_HIGH;
        else if ((c >= 8'h09 && c <= 8'h0D) || c == 8'h20)
            kind = cct_pkg::KIND_SPACE;
        else if (c >= 8'h30 && c <= 8'h39)
            kind = cct_pkg::KIND_DIGIT;
        else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
            kind = cct_pkg::KIND_LETTER;
        else if (c >= 8'h21 && c <= 8'h7E)
            kind = cct_pkg::KIND_PUNCT;
        else
            kind = cct_pkg::KIND_CTRL;
    end

    // transfer into the queue whenever it has room
    assign byte_ch.ready = !fifo_full;
    assign push          = byte_ch.valid && !fifo_full;

    assign push_item.data_byte = byte_ch.byte_in;
    assign push_item.dia       = byte_ch.diacritic_flag;
    assign push_item.last      = byte_ch.query_end;
    assign push_item.kind      = kind;

endmodule

### sv/cct_fifo.sv
// cct_fifo: short queue of classified bytes between the front and back parts
// depends on cct_pkg
module cct_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cct_pkg::item_t  push_item,
    output logic            full,
    output logic            head_valid,
    output cct_pkg::item_t  head,
    input  logic            pop
);

    cct_pkg::item_t                 mem_reg [cct_pkg::FIFO_DEPTH];
    logic [cct_pkg::FIFO_AW-1:0]    wr_ptr_reg;
    logic [cct_pkg::FIFO_AW-1:0]    rd_ptr_reg;
    logic [cct_pkg::FIFO_AW:0]      count_reg;
    logic [cct_pkg::FIFO_AW:0]      count_next;

    assign full       = count_reg == (cct_pkg::FIFO_AW+1)'(cct_pkg::FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    // occupancy after this cycle's push and pop
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (cct_pkg::FIFO_AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (cct_pkg::FIFO_AW+1)'(1);
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + cct_pkg::FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + cct_pkg::FIFO_AW'(1);
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### sv/cct_back.sv
// cct_back: tokenizer state, span decisions and the output register
// depends on cct_pkg and cct_span_if
module cct_back (
    input  logic            clk,
    input  logic            rst_n,
    input  cct_pkg::caps_t  caps,
    input  logic            head_valid,
    input  cct_pkg::item_t  head,
    output logic            pop,
    cct_span_if.source      span_ch
);

    localparam int START_W = cct_pkg::START_W;
    localparam int LEN_W   = cct_pkg::LEN_W;
    localparam int IDX_W   = cct_pkg::IDX_W;

    // tokenizer state
    cct_pkg::run_class_t    cls_reg,   cls_next;
    logic [7:0]             prev_reg,  prev_next;
    logic                   open_reg,  open_next;
    logic [START_W-1:0]     start_reg, start_next;
    logic [LEN_W-1:0]       pos_reg,   pos_next;
    logic [LEN_W-1:0]       count_reg, count_next;
    logic                   second_reg, second_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    cct_pkg::span_t         out_reg, out_next;

    // per byte decision
    logic                   in_range;
    logic [LEN_W-1:0]       pos_after;
    logic                   close_now, single_now, flush_now;
    logic                   open_after;
    logic [START_W-1:0]     start_after;
    cct_pkg::run_class_t    cls_after, run_cls;
    logic [7:0]             prev_after;
    logic [LEN_W-1:0]       close_len, flush_len, count_inc;
    logic                   a0_valid, a1_valid, k0, k1;
    logic [START_W-1:0]     a0_start, a1_start;
    logic [LEN_W-1:0]       a0_len, a1_len;
    cct_pkg::span_t         r0, r1;
    logic                   has_r0, slot_free, load;

    // what the head byte does to the open token
    always_comb
    begin
        in_range    = pos_reg < caps.qcap;
        pos_after   = in_range ? pos_reg + LEN_W'(1) : pos_reg;
        close_now   = 1'b0;
        single_now  = 1'b0;
        open_after  = open_reg;
        start_after = start_reg;
        cls_after   = cls_reg;
        prev_after  = prev_reg;
        run_cls     = (head.kind == cct_pkg::KIND_DIGIT) ? cct_pkg::CLS_DIGIT
                                                         : cct_pkg::CLS_LETTER;
        if (in_range)
        begin
            prev_after = head.data_byte;
            unique case (head.kind) inside
                cct_pkg::KIND_HIGH:
                begin
                    close_now = open_reg && !head.dia && cls_reg != cct_pkg::CLS_NONE
                                && cls_reg != cct_pkg::CLS_HIGH;
                    if (!open_reg || close_now)
                    begin
                        open_after  = 1'b1;
                        start_after = pos_reg[START_W-1:0];
                    end
                    cls_after = cct_pkg::CLS_HIGH;
                end
                cct_pkg::KIND_LETTER, cct_pkg::KIND_DIGIT:
                begin
                    close_now = open_reg && cls_reg != cct_pkg::CLS_NONE
                                && cls_reg != run_cls;
                    if (!open_reg || close_now)
                    begin
                        open_after  = 1'b1;
                        start_after = pos_reg[START_W-1:0];
                    end
                    cls_after = run_cls;
                end
                cct_pkg::KIND_SPACE:
                begin
                    // a repeated whitespace byte adds nothing
                    if (prev_reg != head.data_byte)
                    begin
                        close_now  = open_reg;
                        single_now = 1'b1;
                        open_after = 1'b0;
                    end
                    cls_after = cct_pkg::CLS_NONE;
                end
                cct_pkg::KIND_PUNCT:
                begin
                    close_now  = open_reg;
                    single_now = 1'b1;
                    open_after = 1'b0;
                    cls_after  = cct_pkg::CLS_NONE;
                end
                default:
                begin
                    // control bytes stay inside the token
                    cls_after = cct_pkg::CLS_LETTER;
                end
            endcase
        end
        flush_now = head.last && open_after;
        close_len = pos_reg - {1'b0, start_reg};
        flush_len = pos_after - {1'b0, start_after};
    end

    // order the spans: closed token, one-byte token, flushed token
    always_comb
    begin
        a0_valid = close_now || single_now || flush_now;
        a1_valid = close_now && (single_now || flush_now);
        if (close_now)
        begin
            a0_start = start_reg;
            a0_len   = close_len;
        end
        else if (single_now)
        begin
            a0_start = pos_reg[START_W-1:0];
            a0_len   = LEN_W'(1);
        end
        else
        begin
            a0_start = start_after;
            a0_len   = flush_len;
        end
        if (single_now)
        begin
            a1_start = pos_reg[START_W-1:0];
            a1_len   = LEN_W'(1);
        end
        else
        begin
            a1_start = start_after;
            a1_len   = flush_len;
        end
        count_inc = count_reg + LEN_W'(1);
        k0        = a0_valid && count_reg < caps.tcap;
        k1        = a1_valid && count_inc < caps.tcap;
        has_r0    = k0 || head.last;
    end

    // result words, the end marker when the last byte keeps nothing
    always_comb
    begin
        if (k0)
        begin
            r0.start  = a0_start;
            r0.length = a0_len;
            r0.index  = count_reg[IDX_W-1:0];
            r0.last   = head.last && !k1;
        end
        else
        begin
            r0.start  = '0;
            r0.length = '0;
            r0.index  = '0;
            r0.last   = 1'b1;
        end
        r1.start  = a1_start;
        r1.length = a1_len;
        r1.index  = count_inc[IDX_W-1:0];
        r1.last   = head.last;
    end

    // sequencing: a byte with two spans holds the head until its second span is loaded
    always_comb
    begin
        slot_free   = !out_valid_reg || span_ch.ready;
        pop         = 1'b0;
        load        = 1'b0;
        second_next = second_reg;
        out_next    = out_reg;
        if (head_valid)
        begin
            if (!has_r0)
                pop = 1'b1;
            else if (slot_free)
            begin
                load = 1'b1;
                if (k1 && !second_reg)
                begin
                    out_next    = r0;
                    second_next = 1'b1;
                end
                else
                begin
                    out_next    = second_reg ? r1 : r0;
                    second_next = 1'b0;
                    pop         = 1'b1;
                end
            end
        end
        if (load)
            out_valid_next = 1'b1;
        else if (span_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state after the head byte retires
    always_comb
    begin
        cls_next   = cls_reg;
        prev_next  = prev_reg;
        open_next  = open_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        if (pop)
        begin
            if (head.last)
            begin
                cls_next   = cct_pkg::CLS_NONE;
                prev_next  = '0;
                open_next  = 1'b0;
                start_next = '0;
                pos_next   = '0;
                count_next = '0;
            end
            else
            begin
                cls_next   = cls_after;
                prev_next  = prev_after;
                open_next  = open_after;
                start_next = start_after;
                pos_next   = pos_after;
                count_next = count_reg + LEN_W'(k0) + LEN_W'(k1);
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg       <= cct_pkg::CLS_NONE;
            prev_reg      <= '0;
            open_reg      <= 1'b0;
            start_reg     <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cls_reg       <= cls_next;
            prev_reg      <= prev_next;
            open_reg      <= open_next;
            start_reg     <= start_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign span_ch.valid         = out_valid_reg;
    assign span_ch.span_start    = out_reg.start;
    assign span_ch.span_length   = out_reg.length;
    assign span_ch.span_index    = out_reg.index;
    assign span_ch.last_of_query = out_reg.last;

endmodule

### sv/char_class_tokenizer.sv
// char_class_tokenizer: splits query bytes into token spans by character class
// depends on cct_pkg, cct_channels, cct_front, cct_fifo and cct_back
//
//   channel   dir   transfer when        payload
//   byte_ch   in    valid && ready       byte_in, diacritic_flag, query_end
//   span_ch   out   valid && ready       span_start, span_length, span_index, last_of_query
//   cfg       in    cfg_we               cfg_index, cfg_data (no read-back)
//
// one byte per cycle sustained while span_ch is ready; a byte that yields two spans holds
// the back part until both are loaded, limited by the single output register
// from byte transfer to its first span the path runs through the queue and the output register
// the four-entry queue absorbs output stalls; byte_ch.ready drops only when it is full
// reset clears the token state and sets both limits to 1024; no clearing pass
module char_class_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    cct_byte_if.sink    byte_ch,
    cct_span_if.source  span_ch,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int CFG_W = cct_pkg::CFG_W;

    logic [CFG_W-1:0]   qcap_reg;
    logic [CFG_W-1:0]   tcap_reg;
    cct_pkg::caps_t     caps;
    logic               fifo_full;
    logic               push;
    cct_pkg::item_t     push_item;
    logic               head_valid;
    cct_pkg::item_t     head;
    logic               pop;

    // limit registers, stored already clamped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcap_reg <= CFG_W'(cct_pkg::QUERY_BYTES_MAX);
            tcap_reg <= CFG_W'(cct_pkg::TOKENS_MAX);
        end
        else if (cfg_we)
        begin
            unique case (cct_pkg::cfg_index_t'(cfg_index))
                cct_pkg::REG_MAX_QUERY_BYTES:
                    qcap_reg <= cct_pkg::clamp_cap(cfg_data,
                                                   CFG_W'(cct_pkg::QUERY_BYTES_MAX));
                cct_pkg::REG_MAX_TOKENS:
                    tcap_reg <= cct_pkg::clamp_cap(cfg_data,
                                                   CFG_W'(cct_pkg::TOKENS_MAX));
                default:
                begin
                end
            endcase
        end
    end

    assign caps.qcap = qcap_reg;
    assign caps.tcap = tcap_reg;

    // classifier
    cct_front u_front (
        .byte_ch   (byte_ch),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    // queue
    cct_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (fifo_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // tokenizer
    cct_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .caps       (caps),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .span_ch    (span_ch)
    );

    // an empty span is only ever the end marker
    assert property (@(posedge clk) disable iff (!rst_n)
        span_ch.valid && span_ch.span_length == '0 |->
            span_ch.last_of_query && span_ch.span_start == '0 && span_ch.span_index == '0)
        else $error("empty span that is not an end marker");

    // token ordinal stays under the token limit
    assert property (@(posedge clk) disable iff (!rst_n)
        span_ch.valid |-> {1'b0, span_ch.span_index} < tcap_reg)
        else $error("span index past the token limit");

    // span lies within the examined bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        span_ch.valid |->
            ({2'b00, span_ch.span_start} + {1'b0, span_ch.span_length}) <= {1'b0, qcap_reg})
        else $error("span reaches past the length limit");

endmodule
